>>> src/jsesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsesc_pkg
// types and constants shared by the json string escaper front, queue and back
// ----------------------------------------------------------------------------
package jsesc_pkg;

  // saturation limit of the latched budget
  localparam logic [15:0] MaxBudget = 16'd255;

  localparam logic [7:0] QuoteChar  = 8'h22;
  localparam logic [7:0] BslashChar = 8'h5C;
  localparam logic [7:0] UChar      = 8'h75;
  localparam logic [7:0] ZeroChar   = 8'h30;
  localparam logic [7:0] CtrlLimit  = 8'h20;

  // escaped length of each content kind
  localparam logic [3:0] LenPlain = 4'd1;
  localparam logic [3:0] LenPair  = 4'd2;
  localparam logic [3:0] LenUni   = 4'd6;

  typedef enum logic [1:0] {
    CK_NONE  = 2'd0,
    CK_PLAIN = 2'd1,
    CK_PAIR  = 2'd2,
    CK_UNI   = 2'd3
  } content_kind_e;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic          open_q;
    logic          close_q;
    content_kind_e kind;
    logic [7:0]    data;
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ZeroChar + {4'd0, nib};
    end else begin
      c = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [3:0] kind_len(input content_kind_e k);
    logic [3:0] l;
    case (k)
      CK_PLAIN: l = LenPlain;
      CK_PAIR:  l = LenPair;
      CK_UNI:   l = LenUni;
      default:  l = 4'd0;
    endcase
    return l;
  endfunction

endpackage

>>> src/json_string_escaper_with_budget_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper_with_budget_core
// quotes and escapes a byte stream as a json string under a byte budget
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser                 tlast
//  s_axis    in   [7:0] ref_byte, [15:8] budget  [0] is_first,         is_last
//                                                [1] no_byte
//  m_axis    out  [7:0] out_byte                 [0] run_end           string_end
//
//  an input transaction is taken every cycle while the descriptor queue has room
//  the back sequencer sends one output byte per cycle while m_axis is ready; an item
//  yields 0, 1, 2 or 6 bytes of content plus its quotes, up to 8 bytes in all
//  items that yield nothing never reach the queue
//  reset clears the budget state, the queue pointers and count, and the output valid flag
//  a stalled m_axis holds its byte while the front keeps filling the queue
module json_string_escaper_with_budget_core #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] ref_byte, [15:8] budget
  input  logic [1:0]  s_axis_tuser,   // [0] is_first, [1] no_byte
  input  logic        s_axis_tlast,   // is_last
  // escaped output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [0:0]  m_axis_tuser,   // [0] run_end
  output logic        m_axis_tlast    // string_end
);
  import jsesc_pkg::*;

  // front to queue
  logic  push, full;
  desc_t push_desc;
  // queue to back
  logic  pop, empty;
  desc_t head_desc;

  // budget tracking and classification
  jsesc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ref_byte_i (s_axis_tdata[7:0]),
    .is_first_i (s_axis_tuser[0]),
    .is_last_i  (s_axis_tlast),
    .no_byte_i  (s_axis_tuser[1]),
    .budget_i   (s_axis_tdata[15:8]),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_desc_o   (push_desc)
  );

  // decouples a burst of escape runs from the input side
  jsesc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_desc),
    .empty_o (empty)
  );

  // byte sequencer with registered output
  jsesc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_desc_i     (head_desc),
    .q_empty_i    (empty),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .run_end_o    (m_axis_tuser[0]),
    .string_end_o (m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  // the front only pushes when the queue has room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("descriptor pushed into a full queue");

  // the back only pops a present descriptor
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("descriptor popped from an empty queue");

  // a string start always reaches the queue with its opening quote
  a_first_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0]) |-> (push && push_desc.open_q))
    else $error("string start lost its opening quote");

  // a closing quote always ends its item's run
  a_close_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser[0] && m_axis_tdata == QuoteChar))
    else $error("closing quote without run end");
`endif

endmodule

>>> src/jsesc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsesc_front
// accepts input bytes, tracks the budget and classifies each byte's escape
// ----------------------------------------------------------------------------
module jsesc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            ref_byte_i,
  input  logic                  is_first_i,
  input  logic                  is_last_i,
  input  logic                  no_byte_i,
  input  logic [7:0]            budget_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output jsesc_pkg::desc_t      q_desc_o
);
  import jsesc_pkg::*;

  logic [7:0] used_q, used_d;
  logic [7:0] budget_q, budget_d;
  logic       stopped_q, stopped_d;

  logic          accept;
  logic [7:0]    bud_sat, bud_eff, used_eff;
  logic          stop_eff, fits, emit;
  logic [3:0]    need;
  logic [8:0]    sum;
  content_kind_e kind_raw;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;

  always_comb begin
    if ((ref_byte_i == QuoteChar) || (ref_byte_i == BslashChar)) begin
      kind_raw = CK_PAIR;
    end else if (ref_byte_i < CtrlLimit) begin
      kind_raw = CK_UNI;
    end else begin
      kind_raw = CK_PLAIN;
    end
  end

  always_comb begin
    bud_sat  = ({8'd0, budget_i} > MaxBudget) ? MaxBudget[7:0] : budget_i;
    bud_eff  = is_first_i ? bud_sat : budget_q;
    used_eff = is_first_i ? 8'd0 : used_q;
    stop_eff = is_first_i ? 1'b0 : stopped_q;
    need     = kind_len(kind_raw);
    sum      = {1'b0, used_eff} + {5'd0, need};
    fits     = sum <= {1'b0, bud_eff};
    emit     = !no_byte_i && !stop_eff && fits;

    budget_d  = bud_eff;
    used_d    = emit ? sum[7:0] : used_eff;
    stopped_d = is_last_i || stop_eff || (!no_byte_i && !fits);

    q_desc_o.open_q  = is_first_i;
    q_desc_o.close_q = is_last_i;
    q_desc_o.kind    = emit ? kind_raw : CK_NONE;
    q_desc_o.data    = ref_byte_i;
    // items that give no result never enter the queue
    q_push_o = accept && (is_first_i || is_last_i || emit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= 8'd0;
      budget_q  <= 8'd0;
      stopped_q <= 1'b0;
    end else if (accept) begin
      used_q    <= used_d;
      budget_q  <= budget_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

>>> src/jsesc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsesc_fifo
// short descriptor queue between front and back
// ----------------------------------------------------------------------------
module jsesc_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jsesc_pkg::desc_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output jsesc_pkg::desc_t rdata_o,
  output logic             empty_o
);
  import jsesc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == FullCnt;
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> src/jsesc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsesc_back
// walks each queued descriptor and emits its bytes one per cycle while the output is ready
// ----------------------------------------------------------------------------
module jsesc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jsesc_pkg::desc_t q_desc_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_end_o,
  output logic             string_end_o
);
  import jsesc_pkg::*;

  logic [2:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       run_end_q, string_end_q;

  logic       load, take, last_pos, at_open;
  logic [3:0] len, total;
  logic [2:0] q;
  logic [7:0] content, cur_byte;

  assign load = !valid_q || out_ready_i;
  assign take = load && !q_empty_i;

  always_comb begin
    len      = kind_len(q_desc_i.kind);
    total    = {3'd0, q_desc_i.open_q} + len + {3'd0, q_desc_i.close_q};
    at_open  = q_desc_i.open_q && (idx_q == 3'd0);
    q        = idx_q - {2'd0, q_desc_i.open_q};
    last_pos = ({1'b0, idx_q} + 4'd1) == total;

    case (q_desc_i.kind)
      CK_PAIR: content = (q == 3'd0) ? BslashChar : q_desc_i.data;
      CK_UNI: begin
        case (q)
          3'd0:    content = BslashChar;
          3'd1:    content = UChar;
          3'd2:    content = ZeroChar;
          3'd3:    content = ZeroChar;
          3'd4:    content = hex_char(q_desc_i.data[7:4]);
          default: content = hex_char(q_desc_i.data[3:0]);
        endcase
      end
      default: content = q_desc_i.data;
    endcase

    if (at_open) begin
      cur_byte = QuoteChar;
    end else if ({1'b0, q} < len) begin
      cur_byte = content;
    end else begin
      cur_byte = QuoteChar;
    end
  end

  assign q_pop_o = take && last_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= take;
      if (take) begin
        idx_q <= last_pos ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q       <= cur_byte;
      run_end_q    <= last_pos;
      string_end_q <= last_pos && q_desc_i.close_q;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign run_end_o    = run_end_q;
  assign string_end_o = string_end_q;

endmodule

>>> tb/sv/tb_json_string_escaper_with_budget_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper_with_budget_core
// self-checking bench for the budgeted json string escaper: a short table of
// hand-picked transactions, then random strings and noise, with random gaps on
// the input side and random back-pressure on the output side; every output
// transaction is compared against a typed-in expectation or against a
// behavioural escaper kept in step with the accepted input
// ----------------------------------------------------------------------------
module tb_json_string_escaper_with_budget_core;
  import jsesc_pkg::*;

  localparam int unsigned ClkHigh     = 6;
  localparam int unsigned ClkLow      = 6;
  localparam int unsigned RstCycles   = 3;
  localparam int unsigned NumStrItems = 96;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned CycleLimit  = 200000;
  // lowercase hex digits, first digit in the top byte
  localparam logic [127:0] HexDigits  = "0123456789abcdef";

  // one input item, unpacked from the slave-side bus
  typedef struct packed {
    logic [7:0] ref_byte;
    logic [7:0] budget;
    logic       is_first;
    logic       is_last;
    logic       no_byte;
  } in_item_t;

  // one output byte with its markers
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_beat_t;

  // per accepted item: either a typed-in expectation or none
  typedef struct {
    bit    typed;
    string want;
  } golden_t;

  typedef struct {
    in_item_t item;
    bit       typed;
    string    want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] ref_byte, [15:8] budget
  logic [1:0]  s_axis_tuser;   // [0] is_first, [1] no_byte
  logic        s_axis_tlast;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic [0:0]  m_axis_tuser;   // [0] run_end
  logic        m_axis_tlast;   // string_end

  // escaper state mirrored by the bench
  logic [7:0]  used_cnt;
  logic [7:0]  budget_lat;
  logic        halted;

  logic [7:0]  esc_seq[$];       // bytes yielded by the last predicted item
  out_beat_t   escaped_q[$];     // output transactions still to arrive
  golden_t     golden_q[$];      // items driven, not yet seen accepted
  dir_row_t    dir_rows[$];

  int unsigned err_cnt;
  int unsigned cycle_cnt;
  logic        calm;             // no idling on either side while set

  json_string_escaper_with_budget_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns period
  always begin
    clk_i = 1'b0;
    #ClkLow;
    clk_i = 1'b1;
    #ClkHigh;
  end

  // ------------------------------------------------------------------------
  // behavioural escaper
  // ------------------------------------------------------------------------

  function automatic content_kind_e classify(input logic [7:0] b);
    if (b == QuoteChar || b == BslashChar) return CK_PAIR;
    if (b < CtrlLimit) return CK_UNI;
    return CK_PLAIN;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return HexDigits[8 * (15 - int'(nib)) +: 8];
  endfunction

  // updates the mirrored state and leaves the yielded bytes in esc_seq
  function automatic void escape_item(input in_item_t it);
    content_kind_e kind;
    int            need;
    esc_seq.delete();
    if (it.is_first) begin
      // first always restarts, whatever came before
      budget_lat = (16'(it.budget) > MaxBudget) ? MaxBudget[7:0] : it.budget;
      used_cnt   = 8'd0;
      halted     = 1'b0;
      esc_seq.push_back(QuoteChar);
    end
    if (!it.no_byte && !halted) begin
      kind = classify(it.ref_byte);
      case (kind)
        CK_PAIR: need = 2;
        CK_UNI:  need = 6;
        default: need = 1;
      endcase
      if (int'(used_cnt) + need > int'(budget_lat)) begin
        // escape would not fit whole: drop the rest of the string
        halted = 1'b1;
      end else begin
        case (kind)
          CK_PAIR: begin
            esc_seq.push_back(BslashChar);
            esc_seq.push_back(it.ref_byte);
          end
          CK_UNI: begin
            esc_seq.push_back(BslashChar);
            esc_seq.push_back(UChar);
            esc_seq.push_back(ZeroChar);
            esc_seq.push_back(ZeroChar);
            esc_seq.push_back(hex_digit(it.ref_byte[7:4]));
            esc_seq.push_back(hex_digit(it.ref_byte[3:0]));
          end
          default: esc_seq.push_back(it.ref_byte);
        endcase
        used_cnt = used_cnt + 8'(need);
      end
    end
    if (it.is_last) begin
      // closing quote, and bytes up to the next first are dropped
      esc_seq.push_back(QuoteChar);
      halted = 1'b1;
    end
  endfunction

  // ------------------------------------------------------------------------
  // scoreboard: predict on every input transaction, check every output one
  // ------------------------------------------------------------------------

  always @(posedge clk_i) begin
    in_item_t  it;
    golden_t   g;
    out_beat_t beat;
    out_beat_t want_beat;
    int        n;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.ref_byte = s_axis_tdata[7:0];
        it.budget   = s_axis_tdata[15:8];
        it.is_first = s_axis_tuser[0];
        it.no_byte  = s_axis_tuser[1];
        it.is_last  = s_axis_tlast;
        g.typed = 1'b0;
        g.want  = "";
        if (golden_q.size() != 0) g = golden_q.pop_front();
        escape_item(it);
        // typed rows replace the predicted bytes, markers follow the item
        n = g.typed ? g.want.len() : esc_seq.size();
        for (int i = 0; i < n; i++) begin
          beat.out_byte   = g.typed ? g.want[i] : esc_seq[i];
          beat.run_end    = (i == n - 1);
          beat.string_end = it.is_last && (i == n - 1);
          escaped_q.push_back(beat);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (escaped_q.size() == 0) begin
          $error("output transaction with nothing expected: out_byte %02h", m_axis_tdata);
          err_cnt++;
        end else begin
          want_beat = escaped_q.pop_front();
          if (m_axis_tdata !== want_beat.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want_beat.out_byte, m_axis_tdata);
            err_cnt++;
          end
          if (m_axis_tuser[0] !== want_beat.run_end) begin
            $error("run_end mismatch: expected %0b, actual %0b",
                   want_beat.run_end, m_axis_tuser[0]);
            err_cnt++;
          end
          if (m_axis_tlast !== want_beat.string_end) begin
            $error("string_end mismatch: expected %0b, actual %0b",
                   want_beat.string_end, m_axis_tlast);
            err_cnt++;
          end
        end
      end
    end
  end

  // receiver back-pressure, about a quarter of cycles stalled unless calm
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 24);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  task automatic add_row(input logic [7:0] b, input logic [7:0] bud, input logic f,
                         input logic l, input logic nob, input bit typed,
                         input string want);
    dir_row_t r;
    r.item.ref_byte = b;
    r.item.budget   = bud;
    r.item.is_first = f;
    r.item.is_last  = l;
    r.item.no_byte  = nob;
    r.typed         = typed;
    r.want          = want;
    dir_rows.push_back(r);
  endtask

  // one input transaction, with an optional random gap in front of it
  task automatic drive_item(input in_item_t it, input bit typed, input string want);
    golden_t g;
    g.typed = typed;
    g.want  = want;
    if (!calm && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    golden_q.push_back(g);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.budget, it.ref_byte};
    s_axis_tuser  <= {it.no_byte, it.is_first};
    s_axis_tlast  <= it.is_last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the input off until every expected output transaction has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (escaped_q.size() != 0) @(posedge clk_i);
  endtask

  // mix of escaped, control and plain bytes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? QuoteChar : BslashChar;
      1:       return 8'($urandom_range(0, 31));
      2:       return 8'($urandom_range(32, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    in_item_t    it;
    logic [7:0]  bud;
    int unsigned str_items;
    int unsigned len;
    bit          mid_drained;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    calm          <= 1'b0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    used_cnt       = 8'd0;
    budget_lat     = 8'd0;
    halted         = 1'b0;
    str_items      = 0;
    mid_drained    = 1'b0;

    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    //       byte    budget  first last  none  typed  expected
    // before any string the budget is zero, so nothing comes out
    add_row(8'h41, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, "");
    add_row(8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, "");
    // empty string gives just the two quotes
    add_row(8'hFF, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, "\"\"");
    // full budget: control, quote, backslash, boundary and top bytes
    add_row(8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, "\"\\u0000");
    add_row(8'h1F, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, "\\u001f");
    add_row(8'h22, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, "\\\"");
    add_row(8'h5C, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, "\\\\");
    add_row(8'h20, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, " ");
    add_row(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, "");
    add_row(8'h2F, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, "/");
    // item without a byte inside a string
    add_row(8'h0A, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, "");
    add_row(8'h7F, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, "");
    // byte after the closing quote is dropped
    add_row(8'h42, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, "");
    // zero budget: first byte overflows, closing quote still comes
    add_row(8'h61, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1, "\"");
    add_row(8'h62, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, "");
    add_row(8'h00, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, "\"");
    // budget reached exactly, then overflow
    add_row(8'h22, 8'h03, 1'b1, 1'b0, 1'b0, 1'b0, "");
    add_row(8'h78, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, "");
    add_row(8'h79, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, "");
    add_row(8'h7A, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, "");
    // unicode escape one byte short of the budget, no closing quote
    add_row(8'h01, 8'h05, 1'b1, 1'b0, 1'b0, 1'b0, "");
    // restart without a last before it
    add_row(8'h0A, 8'h06, 1'b1, 1'b0, 1'b0, 1'b0, "");
    // single-item strings, the second one with the longest run
    add_row(8'h41, 8'h01, 1'b1, 1'b1, 1'b0, 1'b1, "\"A\"");
    add_row(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, "\"\\u0000\"");

    foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // input held off until the output side has caught up
    wait_drained();

    // random part: mostly well-formed strings, some empty ones and noise
    while (str_items < NumStrItems) begin
      calm <= (str_items >= 50 && str_items < 80);
      if (!mid_drained && str_items >= 90) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:11]: begin
          // noise, flags and bytes all random
          it.ref_byte = 8'($urandom);
          it.budget   = 8'($urandom);
          it.is_first = 1'($urandom);
          it.is_last  = 1'($urandom);
          it.no_byte  = 1'($urandom);
          drive_item(it, 1'b0, "");
        end
        [12:17]: begin
          it.ref_byte = 8'($urandom);
          it.budget   = 8'($urandom);
          it.is_first = 1'b1;
          it.is_last  = 1'b1;
          it.no_byte  = 1'b1;
          drive_item(it, 1'b0, "");
          str_items++;
        end
        default: begin
          // small budgets most of the time so that overflow is common
          bud = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
          len = $urandom_range(1, 8);
          for (int unsigned k = 0; k < len; k++) begin
            it.ref_byte = pick_byte();
            it.budget   = (k == 0) ? bud : 8'($urandom);
            it.is_first = (k == 0);
            it.is_last  = (k == len - 1);
            it.no_byte  = ($urandom_range(15) == 0);
            drive_item(it, 1'b0, "");
            str_items++;
          end
        end
      endcase
    end
    calm <= 1'b0;

    // drain, then keep watching for any stray output
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (escaped_q.size() != 0) begin
      $error("%0d output transactions never arrived", escaped_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> json_string_escaper_with_budget_core.f
src/jsesc_pkg.sv
src/jsesc_front.sv
src/jsesc_fifo.sv
src/jsesc_back.sv
src/json_string_escaper_with_budget_core.sv
tb/sv/tb_json_string_escaper_with_budget_core.sv
